// ===== rtl/core/obbq_pkg.sv =====
package obbq_pkg;

	// Field and datapath widths
	localparam int unsigned COORD_W    = 32;
	localparam int unsigned COMP_W     = 16;
	localparam int unsigned EXT_W      = 32;
	localparam int unsigned AXIS_FRAC  = 14;
	localparam int unsigned DIFF_W     = COORD_W + 1;
	localparam int unsigned SCAL_W     = EXT_W + 1;
	localparam int unsigned PROD_W     = DIFF_W + COMP_W;
	localparam int unsigned ACC_W      = PROD_W + 2;
	localparam int unsigned PROJ_W     = ACC_W - AXIS_FRAC;
	localparam int unsigned SUM_W      = PROJ_W + 1;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CORNER_W   = 3;
	localparam int unsigned IN_TDATA_W  = 104;
	localparam int unsigned OUT_TDATA_W = 96;

	// Register reset values: axes start as the unit x, y and z vectors
	localparam logic [47:0] AXIS0_RST = 48'h0000_0000_4000;
	localparam logic [47:0] AXIS1_RST = 48'h0000_4000_0000;
	localparam logic [47:0] AXIS2_RST = 48'h4000_0000_0000;

	// Saturation bounds
	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X      = 3'd0,
		REG_CENTER_Y      = 3'd1,
		REG_CENTER_Z      = 3'd2,
		REG_AXIS_ZERO     = 3'd3,
		REG_AXIS_ONE      = 3'd4,
		REG_AXIS_TWO      = 3'd5,
		REG_HALF_EXT_LOW  = 3'd6,
		REG_HALF_EXT_HIGH = 3'd7
	} cfg_reg_t;

	// Box as seen by the datapath; axis[k][c] is component c of axis k
	typedef struct packed {
		logic [2:0][COORD_W-1:0]        center;
		logic [2:0][2:0][COMP_W-1:0]    axis;
		logic [2:0][EXT_W-1:0]          ext;
	} box_t;

endpackage

// ===== rtl/core/obbq_cfg.sv =====
module obbq_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [obbq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [obbq_pkg::CFG_DATA_W-1:0] cfg_data,
	output obbq_pkg::box_t                  box
);
	import obbq_pkg::*;

	logic [COORD_W-1:0] center_q [3];
	logic [47:0]        axis_q [3];
	logic [63:0]        ext_lo_q;
	logic [30:0]        ext_hi_q;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			axis_q[0]   <= AXIS0_RST;
			axis_q[1]   <= AXIS1_RST;
			axis_q[2]   <= AXIS2_RST;
			ext_lo_q    <= '0;
			ext_hi_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:      center_q[0] <= cfg_data[31:0];
				REG_CENTER_Y:      center_q[1] <= cfg_data[31:0];
				REG_CENTER_Z:      center_q[2] <= cfg_data[31:0];
				REG_AXIS_ZERO:     axis_q[0]   <= cfg_data[47:0];
				REG_AXIS_ONE:      axis_q[1]   <= cfg_data[47:0];
				REG_AXIS_TWO:      axis_q[2]   <= cfg_data[47:0];
				REG_HALF_EXT_LOW:  ext_lo_q    <= cfg_data;
				REG_HALF_EXT_HIGH: ext_hi_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Unpack into the box view
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			box.center[k] = center_q[k];
			for (int c = 0; c < 3; c++) begin
				box.axis[k][c] = axis_q[k][COMP_W*c +: COMP_W];
			end
		end
		box.ext[0] = ext_lo_q[31:0];
		box.ext[1] = ext_lo_q[63:32];
		box.ext[2] = {1'b0, ext_hi_q};
	end

endmodule

// ===== rtl/core/obbq_proj.sv =====
module obbq_proj (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  obbq_pkg::box_t                       box,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 in_action,
	input  logic [2:0][obbq_pkg::COORD_W-1:0]    in_point,
	input  logic [obbq_pkg::CORNER_W-1:0]        in_corner,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0][obbq_pkg::SCAL_W-1:0]     out_scal
);
	import obbq_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic                       action_s1, action_s2, action_s3;
	logic [CORNER_W-1:0]        corner_s1, corner_s2, corner_s3;
	logic signed [DIFF_W-1:0]   diff_s1 [3];
	logic signed [PROD_W-1:0]   prod_s2 [3][3];
	logic signed [ACC_W-1:0]    acc_s3 [3];
	logic signed [SCAL_W-1:0]   scal_s4 [3];

	// Stage handshake: a stage loads when empty or when its successor moves
	assign adv_s4   = !vld_s4 || out_ready;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;
	assign out_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	// s1: offset from center
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			action_s1 <= in_action;
			corner_s1 <= in_corner;
			for (int c = 0; c < 3; c++) begin
				diff_s1[c] <= $signed({in_point[c][COORD_W-1], in_point[c]})
					- $signed({box.center[c][COORD_W-1], box.center[c]});
			end
		end
	end

	// s2: offset component times axis component
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			action_s2 <= action_s1;
			corner_s2 <= corner_s1;
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[k][c] <= diff_s1[c] * $signed(box.axis[k][c]);
				end
			end
		end
	end

	// s3: dot product per axis
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			action_s3 <= action_s2;
			corner_s3 <= corner_s2;
			for (int k = 0; k < 3; k++) begin
				acc_s3[k] <= ACC_W'(prod_s2[k][0]) + ACC_W'(prod_s2[k][1])
					+ ACC_W'(prod_s2[k][2]);
			end
		end
	end

	// s4: floor shift and clamp, or corner sign select
	always_ff @(posedge clk) begin
		logic signed [PROJ_W-1:0] proj;
		logic signed [PROJ_W-1:0] ext_p;
		logic signed [SCAL_W-1:0] ext_s;
		if (adv_s4) begin
			for (int k = 0; k < 3; k++) begin
				proj  = acc_s3[k][ACC_W-1:AXIS_FRAC];
				ext_p = $signed({{(PROJ_W-EXT_W){1'b0}}, box.ext[k]});
				ext_s = $signed({1'b0, box.ext[k]});
				if (action_s3) begin
					scal_s4[k] <= corner_s3[k] ? ext_s : -ext_s;
				end else if (proj > ext_p) begin
					scal_s4[k] <= ext_s;
				end else if (proj < -ext_p) begin
					scal_s4[k] <= -ext_s;
				end else begin
					scal_s4[k] <= proj[SCAL_W-1:0];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			out_scal[k] = scal_s4[k];
		end
	end

endmodule

// ===== rtl/core/obbq_recon.sv =====
module obbq_recon (
	input  logic                              clk,
	input  logic                              arst_n,
	input  obbq_pkg::box_t                    box,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0][obbq_pkg::SCAL_W-1:0]  in_scal,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0][obbq_pkg::COORD_W-1:0] out_result
);
	import obbq_pkg::*;

	logic vld_s5, vld_s6, vld_s7;
	logic adv_s5, adv_s6, adv_s7;

	logic signed [PROD_W-1:0] prod_s5 [3][3];
	logic signed [ACC_W-1:0]  acc_s6 [3];
	logic [COORD_W-1:0]       res_s7 [3];

	assign adv_s7    = !vld_s7 || out_ready;
	assign adv_s6    = !vld_s6 || adv_s7;
	assign adv_s5    = !vld_s5 || adv_s6;
	assign in_ready  = adv_s5;
	assign out_valid = vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s5) vld_s5 <= in_valid;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	// s5: scalar along axis k times component c of that axis
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s5[c][k] <= $signed(in_scal[k]) * $signed(box.axis[k][c]);
				end
			end
		end
	end

	// s6: offset per output coordinate
	always_ff @(posedge clk) begin
		if (adv_s6) begin
			for (int c = 0; c < 3; c++) begin
				acc_s6[c] <= ACC_W'(prod_s5[c][0]) + ACC_W'(prod_s5[c][1])
					+ ACC_W'(prod_s5[c][2]);
			end
		end
	end

	// s7: floor shift, add center, saturate (output register)
	always_ff @(posedge clk) begin
		logic signed [SUM_W-1:0] sum;
		if (adv_s7) begin
			for (int c = 0; c < 3; c++) begin
				sum = $signed({acc_s6[c][ACC_W-1], acc_s6[c][ACC_W-1:AXIS_FRAC]})
					+ $signed({{(SUM_W-COORD_W){box.center[c][COORD_W-1]}},
						box.center[c]});
				if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1) begin
					res_s7[c] <= sum[COORD_W-1:0];
				end else if (sum[SUM_W-1]) begin
					res_s7[c] <= COORD_MIN;
				end else begin
					res_s7[c] <= COORD_MAX;
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			out_result[c] = res_s7[c];
		end
	end

endmodule

// ===== rtl/core/obb_point_query_core.sv =====
// Closest point on / corner of one oriented bounding box.
// Pipeline: an input transfer passes through 4 projection stages and then 3
// reconstruction stages before m_tvalid rises (9 multipliers in each half).
// Throughput: one item per cycle; m_tready low backs up the pipeline one stage
// at a time, so s_tready drops only once every stage holds an item.
// Reset: arst_n clears all stage valid bits and loads the register defaults.
module obb_point_query_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [obbq_pkg::IN_TDATA_W-1:0]       s_tdata,  // point_x, point_y, point_z, corner_index
	input  logic                                  s_tuser,  // action
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [obbq_pkg::OUT_TDATA_W-1:0]      m_tdata,  // result_x, result_y, result_z
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [obbq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [obbq_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import obbq_pkg::*;

	box_t                    box;
	logic [2:0][COORD_W-1:0] point;
	logic                    mid_valid, mid_ready;
	logic [2:0][SCAL_W-1:0]  mid_scal;
	logic [2:0][COORD_W-1:0] result;

	assign point[0] = s_tdata[31:0];
	assign point[1] = s_tdata[63:32];
	assign point[2] = s_tdata[95:64];

	obbq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.box       (box)
	);

	obbq_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.box       (box),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_point  (point),
		.in_corner (s_tdata[98:96]),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_scal  (mid_scal)
	);

	obbq_recon u_recon (
		.clk        (clk),
		.arst_n     (arst_n),
		.box        (box),
		.in_valid   (mid_valid),
		.in_ready   (mid_ready),
		.in_scal    (mid_scal),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {result[2], result[1], result[0]};

endmodule

// ===== rtl/core/obbq_chk.sv =====
module obbq_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [obbq_pkg::OUT_TDATA_W-1:0] m_tdata
);
	logic [3:0] inflight_q;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_only_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 4'd0)
		else $error("result without a pending input");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'd7)
		else $error("more items in flight than pipeline stages");

endmodule

bind obb_point_query_core obbq_chk u_obbq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
